/* hdl/ipv4_flow_counter_table_macros.svh */
// Assertion macros used by the flow counter table checker
`ifndef IPV4_FLOW_COUNTER_TABLE_MACROS_SVH
`define IPV4_FLOW_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow counter table check failed");

// Next-cycle implication, disabled while reset is asserted
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow counter table check failed");

`endif

/* hdl/fct_pkg.sv */
// Package: shared types and constants of the flow counter table
`default_nettype none
package fct_pkg;

    localparam int ADDR_W    = 32;
    localparam int PROTO_W   = 8;
    localparam int KEY_W     = 2 * ADDR_W + PROTO_W;
    localparam int COUNT_W   = 64;
    localparam int WORD_W    = KEY_W + 2 * COUNT_W;
    localparam int SLOT_W    = 12;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [15:0] MIN_HEADER_BYTES = 16'd34;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [31:0] RESET_LAN_BASE   = 32'h0001A8C0;
    localparam logic [31:0] RESET_LAN_MASK   = 32'h00FFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_LAN_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAN_MASK = 8'd1;

    localparam logic [STATUS_W-1:0] STAT_SHORT    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_IPV4 = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    typedef struct packed {
        logic load;
        logic issue;
        logic capture;
        logic update;
        logic insert;
        logic full_drop;
        logic out_load;
    } fct_cmd_t;

    typedef struct packed {
        logic drop;
        logic scan_more;
        logic pend;
        logic hit;
        logic full;
        logic out_free;
    } fct_stat_t;

endpackage
`default_nettype wire

/* hdl/ipv4_flow_counter_table.sv */
// Top level: IPv4 flow counter table, controller plus datapath
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | sink      | in_valid / in_ready    | captured_length .. protocol (header fields)
//  out     | source    | out_valid / out_ready  | status, slot, masked keys, totals
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data (0 base, 1 mask)
//
// One request at a time. Short and non-IPv4 frames go from acceptance straight to
// the response state, which loads the result register. IPv4 frames scan the table
// RAM one entry per cycle from slot 0 up to the fill count; the single RAM read port
// sets that rate. A hit updates its entry; a miss appends one unless the table is
// full. The next request is taken in the cycle after the result loads. Reset clears
// the fill count, so no RAM clearing pass is needed. A stalled result holds in the
// output register; the next request is still accepted and processed, and its result
// waits in the response state until the output register frees.
`default_nettype none
module ipv4_flow_counter_table #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [15:0]                   captured_length,
    input  wire logic [15:0]                   frame_length,
    input  wire logic [15:0]                   ethertype,
    input  wire logic [31:0]                   source_address,
    input  wire logic [31:0]                   destination_address,
    input  wire logic [7:0]                    protocol,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fct_pkg::STATUS_W-1:0]       status,
    output logic [fct_pkg::SLOT_W-1:0]         slot,
    output logic [31:0]                        masked_source,
    output logic [31:0]                        masked_destination,
    output logic [63:0]                        packet_total,
    output logic [63:0]                        byte_total
);
    import fct_pkg::*;

    fct_cmd_t  cmd;
    fct_stat_t st;

    // Config writes land directly in the datapath registers; always take them
    assign cfg_ready = 1'b1;

    fct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    fct_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .captured_length     (captured_length),
        .frame_length        (frame_length),
        .ethertype           (ethertype),
        .source_address      (source_address),
        .destination_address (destination_address),
        .protocol            (protocol),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .status              (status),
        .slot                (slot),
        .masked_source       (masked_source),
        .masked_destination  (masked_destination),
        .packet_total        (packet_total),
        .byte_total          (byte_total),
        .cmd                 (cmd),
        .st                  (st)
    );
endmodule
`default_nettype wire

/* hdl/fct_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/fct_ctrl.sv */
// Controller: sequences classify, table scan, update, insert or full drop, and response
`default_nettype none
module fct_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fct_pkg::fct_stat_t st,
    output fct_pkg::fct_cmd_t      cmd
);
    import fct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_UPD  = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.drop ? S_RESP : S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (st.hit)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPD;
                end
                else if (st.scan_more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!st.pend)
                begin
                    cmd.full_drop = st.full;
                    cmd.insert    = !st.full;
                    state_next    = S_RESP;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/fct_dp.sv */
// Datapath: config registers, key build, table RAM, counters and result register
`default_nettype none
module fct_dp #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic [15:0]                       captured_length,
    input  wire logic [15:0]                       frame_length,
    input  wire logic [15:0]                       ethertype,
    input  wire logic [31:0]                       source_address,
    input  wire logic [31:0]                       destination_address,
    input  wire logic [7:0]                        protocol,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [fct_pkg::STATUS_W-1:0]           status,
    output logic [fct_pkg::SLOT_W-1:0]             slot,
    output logic [31:0]                            masked_source,
    output logic [31:0]                            masked_destination,
    output logic [63:0]                            packet_total,
    output logic [63:0]                            byte_total,
    input  wire fct_pkg::fct_cmd_t                 cmd,
    output fct_pkg::fct_stat_t                     st
);
    import fct_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [31:0] base_reg, mask_reg;
    logic [31:0] src_reg, dst_reg;
    logic [7:0]  proto_reg;
    logic [15:0] flen_reg;
    logic [CW-1:0] scan_reg, used_reg;
    logic          pend_reg;
    logic [IW-1:0] pend_idx_reg, hit_idx_reg;
    logic [COUNT_W-1:0] hit_pk_reg, hit_by_reg;
    logic [STATUS_W-1:0] stat_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [COUNT_W-1:0]  pk_tot_reg, by_tot_reg;
    logic                out_valid_reg;

    logic [31:0] msrc, mdst;
    logic        is_short, not_ipv4;
    logic [KEY_W-1:0]  key;
    logic              we;
    logic [IW-1:0]     waddr;
    logic [WORD_W-1:0] wdata, rdata;
    logic [COUNT_W-1:0] pk_inc, by_inc;

    assign is_short = captured_length < MIN_HEADER_BYTES;
    assign not_ipv4 = ethertype != ETHERTYPE_IPV4;
    assign msrc = ((source_address & mask_reg) == base_reg) ? source_address : 32'd0;
    assign mdst = ((destination_address & mask_reg) == base_reg) ?
                  destination_address : 32'd0;
    assign key  = {src_reg, dst_reg, proto_reg};

    assign pk_inc = hit_pk_reg + 64'd1;
    assign by_inc = hit_by_reg + COUNT_W'(flen_reg);

    assign we    = cmd.update | cmd.insert;
    assign waddr = cmd.update ? hit_idx_reg : used_reg[IW-1:0];
    assign wdata = cmd.update ? {key, pk_inc, by_inc} :
                                {key, 64'd1, COUNT_W'(flen_reg)};

    fct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (scan_reg[IW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        st.drop      = is_short | not_ipv4;
        st.scan_more = scan_reg < used_reg;
        st.pend      = pend_reg;
        st.hit       = pend_reg && (rdata[WORD_W-1 -: KEY_W] == key);
        st.full      = used_reg == CW'(TABLE_ENTRIES);
        st.out_free  = !out_valid_reg || out_ready;
    end

    // Control state: config, fill count, scan pointer, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= RESET_LAN_BASE;
            mask_reg      <= RESET_LAN_MASK;
            used_reg      <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_LAN_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_LAN_MASK)
            begin
                mask_reg <= cfg_data;
            end
            if (cmd.insert)
            begin
                used_reg <= used_reg + CW'(1);
            end
            if (cmd.load)
            begin
                scan_reg <= '0;
            end
            else if (cmd.issue)
            begin
                scan_reg <= scan_reg + CW'(1);
            end
            pend_reg <= cmd.issue;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg    <= st.drop ? 32'd0 : msrc;
            dst_reg    <= st.drop ? 32'd0 : mdst;
            proto_reg  <= protocol;
            flen_reg   <= frame_length;
            stat_reg   <= is_short ? STAT_SHORT : STAT_NOT_IPV4;
            slot_reg   <= '0;
            pk_tot_reg <= '0;
            by_tot_reg <= '0;
        end
        if (cmd.issue)
        begin
            pend_idx_reg <= scan_reg[IW-1:0];
        end
        if (cmd.capture)
        begin
            hit_idx_reg <= pend_idx_reg;
            hit_pk_reg  <= rdata[2*COUNT_W-1:COUNT_W];
            hit_by_reg  <= rdata[COUNT_W-1:0];
        end
        if (cmd.update)
        begin
            stat_reg   <= STAT_UPDATED;
            slot_reg   <= SLOT_W'(hit_idx_reg);
            pk_tot_reg <= pk_inc;
            by_tot_reg <= by_inc;
        end
        if (cmd.insert)
        begin
            stat_reg   <= STAT_INSERTED;
            slot_reg   <= SLOT_W'(used_reg[IW-1:0]);
            pk_tot_reg <= 64'd1;
            by_tot_reg <= COUNT_W'(flen_reg);
        end
        if (cmd.full_drop)
        begin
            stat_reg <= STAT_FULL;
        end
        if (cmd.out_load)
        begin
            status             <= stat_reg;
            slot               <= slot_reg;
            masked_source      <= src_reg;
            masked_destination <= dst_reg;
            packet_total       <= pk_tot_reg;
            byte_total         <= by_tot_reg;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

/* hdl/fct_checker.sv */
// Port-level checker for the flow counter table, bound to the top level
`default_nettype none
`include "ipv4_flow_counter_table_macros.svh"
module fct_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [11:0] slot,
    input wire logic [31:0] masked_source,
    input wire logic [31:0] masked_destination,
    input wire logic [63:0] packet_total
);
    import fct_pkg::*;

    logic no_entry, no_key;

    assign no_key   = (status == STAT_SHORT) || (status == STAT_NOT_IPV4);
    assign no_entry = no_key || (status == STAT_FULL);

    `FCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `FCT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `FCT_ASSERT_IMPLY(a_status_range, clk, rst_n, out_valid, status <= STAT_FULL)
    `FCT_ASSERT_IMPLY(a_no_slot, clk, rst_n, out_valid && no_entry, slot == '0 && packet_total == '0)
    `FCT_ASSERT_IMPLY(a_no_key, clk, rst_n, out_valid && no_key, masked_source == '0 && masked_destination == '0)
endmodule

bind ipv4_flow_counter_table fct_checker u_fct_checker (.*);
`default_nettype wire
